// File: hw/rtl/wmmd_pkg.sv
// wmmd_pkg: shared types and constants of the waveform min/max decimator
// used by every module of the block; no dependencies

package wmmd_pkg;

   localparam int MAX_CHANNELS  = 8;
   localparam int SAMPLE_BITS   = 24;
   localparam int CH_BITS       = 4;
   localparam int FPP_BITS      = 17;
   localparam int PTNUM_BITS    = 32;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 17;
   // sum of up to eight samples needs three extra bits
   localparam int SUM_BITS      = SAMPLE_BITS + 3;
   localparam int DIV_CNT_BITS  = $clog2(SUM_BITS);

   localparam logic [CH_BITS-1:0]  CHANNEL_COUNT_RESET    = 4'd2;
   localparam logic [FPP_BITS-1:0] FRAMES_PER_POINT_RESET = 17'd512;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_POS_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_NEG_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   localparam logic [CSR_IDX_BITS-1:0] CSR_CHANNEL_COUNT    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FRAMES_PER_POINT = 2'd1;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_ch0;
      logic signed [SAMPLE_BITS-1:0] sample_ch1;
      logic signed [SAMPLE_BITS-1:0] sample_ch2;
      logic signed [SAMPLE_BITS-1:0] sample_ch3;
      logic signed [SAMPLE_BITS-1:0] sample_ch4;
      logic signed [SAMPLE_BITS-1:0] sample_ch5;
      logic signed [SAMPLE_BITS-1:0] sample_ch6;
      logic signed [SAMPLE_BITS-1:0] sample_ch7;
      logic                          final_frame;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] point_min;
      logic signed [SAMPLE_BITS-1:0] point_max;
      logic [PTNUM_BITS-1:0]         point_number;
      logic                          last_point;
   } rsp_payload_type;

   // one classified frame waiting for the back end
   typedef struct packed {
      logic signed [SUM_BITS-1:0] sum;
      logic [CH_BITS-1:0]         chans;
      logic                       final_frame;
   } work_item_type;

endpackage

// File: hw/rtl/wmmd_front.sv
// wmmd_front: accepts frames, sums the active channels, pushes work items
// depends on wmmd_pkg

module wmmd_front (
   input  wmmd_pkg::req_payload_type req_payload,
   input  logic [wmmd_pkg::CH_BITS-1:0] channel_count,
   output wmmd_pkg::work_item_type   push_item
);

   logic signed [wmmd_pkg::SAMPLE_BITS-1:0] samples [wmmd_pkg::MAX_CHANNELS];
   logic [wmmd_pkg::CH_BITS-1:0]            n_eff;
   logic signed [wmmd_pkg::SUM_BITS-1:0]    sum;

   assign samples[0] = req_payload.sample_ch0;
   assign samples[1] = req_payload.sample_ch1;
   assign samples[2] = req_payload.sample_ch2;
   assign samples[3] = req_payload.sample_ch3;
   assign samples[4] = req_payload.sample_ch4;
   assign samples[5] = req_payload.sample_ch5;
   assign samples[6] = req_payload.sample_ch6;
   assign samples[7] = req_payload.sample_ch7;

   // zero counts as one channel, anything above the maximum saturates
   always_comb begin
      if (channel_count == '0) begin
         n_eff = wmmd_pkg::CH_BITS'(1);
      end else if (channel_count > wmmd_pkg::CH_BITS'(wmmd_pkg::MAX_CHANNELS)) begin
         n_eff = wmmd_pkg::CH_BITS'(wmmd_pkg::MAX_CHANNELS);
      end else begin
         n_eff = channel_count;
      end
   end

   always_comb begin
      sum = '0;
      for (int c = 0; c < wmmd_pkg::MAX_CHANNELS; c++) begin
         if (wmmd_pkg::CH_BITS'(c) < n_eff) begin
            sum = sum + wmmd_pkg::SUM_BITS'(samples[c]);
         end
      end
   end

   assign push_item.sum         = sum;
   assign push_item.chans       = n_eff;
   assign push_item.final_frame = req_payload.final_frame;

endmodule

// File: hw/rtl/wmmd_queue.sv
// wmmd_queue: short fifo of work items between front and back end
// depends on wmmd_pkg

module wmmd_queue #(
   parameter int DEPTH = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  wmmd_pkg::work_item_type push_item,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output wmmd_pkg::work_item_type pop_item
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   wmmd_pkg::work_item_type entries_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != CNT_BITS'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: hw/rtl/wmmd_back.sv
// wmmd_back: bit-serial divide to mono, min/max tracking, point output register
// depends on wmmd_pkg

module wmmd_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              pop_valid,
   output logic                              pop_ready,
   input  wmmd_pkg::work_item_type           pop_item,
   input  logic [wmmd_pkg::FPP_BITS-1:0]     frames_per_point,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output wmmd_pkg::rsp_payload_type         rsp_payload
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_POST = 3'b100
   } back_state_type;

   localparam int SB = wmmd_pkg::SUM_BITS;
   localparam int CB = wmmd_pkg::CH_BITS;

   back_state_type state_ff, state_in;

   logic [SB-1:0]                         quot_ff, quot_in;
   logic [CB-1:0]                         rem_ff, rem_in;
   logic [CB-1:0]                         divisor_ff, divisor_in;
   logic                                  neg_ff, neg_in;
   logic                                  final_ff, final_in;
   logic [wmmd_pkg::DIV_CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic signed [wmmd_pkg::SAMPLE_BITS-1:0] min_ff, min_in;
   logic signed [wmmd_pkg::SAMPLE_BITS-1:0] max_ff, max_in;
   logic [wmmd_pkg::FPP_BITS-1:0]         pending_ff, pending_in;
   logic [wmmd_pkg::PTNUM_BITS-1:0]       points_ff, points_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   wmmd_pkg::rsp_payload_type             rsp_payload_ff, rsp_payload_in;

   logic [SB-1:0]                         sum_mag;
   logic [CB-1:0]                         rem_shift;
   logic                                  rem_ge;
   logic [SB-1:0]                         mono_wide;
   logic signed [wmmd_pkg::SAMPLE_BITS-1:0] mono;
   logic signed [wmmd_pkg::SAMPLE_BITS-1:0] min_next, max_next;
   logic [wmmd_pkg::FPP_BITS-1:0]         pending_next, fpp_eff;
   logic                                  emit, out_free;

   assign pop_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // magnitude of the channel sum, the most negative sum still fits unsigned
   assign sum_mag = pop_item.sum[SB-1] ? (SB'(0) - SB'(pop_item.sum)) : SB'(pop_item.sum);

   // restoring divide, one quotient bit a cycle
   assign rem_shift = {rem_ff[CB-2:0], quot_ff[SB-1]};
   assign rem_ge    = (rem_shift >= divisor_ff);

   assign mono_wide    = neg_ff ? (SB'(0) - quot_ff) : quot_ff;
   assign mono         = signed'(mono_wide[wmmd_pkg::SAMPLE_BITS-1:0]);
   assign min_next     = (mono < min_ff) ? mono : min_ff;
   assign max_next     = (mono > max_ff) ? mono : max_ff;
   assign pending_next = pending_ff + 1'b1;
   assign fpp_eff      = (frames_per_point == '0) ? wmmd_pkg::FPP_BITS'(1) : frames_per_point;
   assign emit         = final_ff || (pending_next >= fpp_eff);
   assign out_free     = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in       = state_ff;
      quot_in        = quot_ff;
      rem_in         = rem_ff;
      divisor_in     = divisor_ff;
      neg_in         = neg_ff;
      final_in       = final_ff;
      cnt_in         = cnt_ff;
      min_in         = min_ff;
      max_in         = max_ff;
      pending_in     = pending_ff;
      points_in      = points_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               quot_in    = sum_mag;
               rem_in     = '0;
               divisor_in = pop_item.chans;
               neg_in     = pop_item.sum[SB-1];
               final_in   = pop_item.final_frame;
               cnt_in     = wmmd_pkg::DIV_CNT_BITS'(SB - 1);
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            quot_in = {quot_ff[SB-2:0], rem_ge};
            rem_in  = rem_ge ? (rem_shift - divisor_ff) : rem_shift;
            if (cnt_ff == '0) begin
               state_in = ST_POST;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_POST: begin
            if (!emit) begin
               min_in     = min_next;
               max_in     = max_next;
               pending_in = pending_next;
               state_in   = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_payload_in.point_min    = min_next;
               rsp_payload_in.point_max    = max_next;
               rsp_payload_in.point_number = points_ff;
               rsp_payload_in.last_point   = final_ff;
               points_in                   = points_ff + 1'b1;
               min_in                      = wmmd_pkg::SAMPLE_POS_MAX;
               max_in                      = wmmd_pkg::SAMPLE_NEG_MIN;
               pending_in                  = '0;
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_ff       <= wmmd_pkg::SAMPLE_POS_MAX;
         max_ff       <= wmmd_pkg::SAMPLE_NEG_MIN;
         pending_ff   <= '0;
         points_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         pending_ff   <= pending_in;
         points_ff    <= points_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff        <= quot_in;
      rem_ff         <= rem_in;
      divisor_ff     <= divisor_in;
      neg_ff         <= neg_in;
      final_ff       <= final_in;
      cnt_ff         <= cnt_in;
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

// File: hw/rtl/waveform_minmax_decimator_core.sv
// a point leaves once the request that completes it has passed the queue, the back
//    end's idle/pop state, the bit steps of its divide state, its update state and
//    then the output register; when a point is due the update state waits for room
// the front end and a short queue take requests while the back end divides
// reset: synchronous, active high; clears trackers, point count, queue state and
//    configuration registers to their defaults, no clearing pass

module waveform_minmax_decimator_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel: one multichannel frame per request
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  wmmd_pkg::req_payload_type             req_payload,
   // result channel: one waveform point
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output wmmd_pkg::rsp_payload_type             rsp_payload,
   // register write port
   input  logic                                  csr_write_enable,
   input  logic [wmmd_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [wmmd_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);

   // configuration registers
   logic [wmmd_pkg::CH_BITS-1:0]  channel_count_ff, channel_count_in;
   logic [wmmd_pkg::FPP_BITS-1:0] frames_per_point_ff, frames_per_point_in;

   // front to queue
   wmmd_pkg::work_item_type push_item;
   logic                    push_ready;

   // queue to back end
   wmmd_pkg::work_item_type pop_item;
   logic                    pop_valid;
   logic                    pop_ready;

   // register decode; unknown indexes are dropped
   always_comb begin
      channel_count_in    = channel_count_ff;
      frames_per_point_in = frames_per_point_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            wmmd_pkg::CSR_CHANNEL_COUNT: begin
               channel_count_in = csr_write_data[wmmd_pkg::CH_BITS-1:0];
            end
            wmmd_pkg::CSR_FRAMES_PER_POINT: begin
               frames_per_point_in = csr_write_data[wmmd_pkg::FPP_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff    <= wmmd_pkg::CHANNEL_COUNT_RESET;
         frames_per_point_ff <= wmmd_pkg::FRAMES_PER_POINT_RESET;
      end else begin
         channel_count_ff    <= channel_count_in;
         frames_per_point_ff <= frames_per_point_in;
      end
   end

   // request is taken whenever the queue has room
   assign req_ready = push_ready;

   // front end: clamp channel count and sum the active channels
   wmmd_front u_front (
      .req_payload   (req_payload),
      .channel_count (channel_count_ff),
      .push_item     (push_item)
   );

   // decoupling queue, lets the front keep accepting while the divider runs
   wmmd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // back end: divide to mono, track min/max, emit points through an output register
   wmmd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_item         (pop_item),
      .frames_per_point (frames_per_point_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload)
   );

endmodule

// File: hw/rtl/wmmd_checker.sv
// wmmd_checker: port-level checks on the result channel of the decimator
// depends on wmmd_pkg; bound to waveform_minmax_decimator_core

module wmmd_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input wmmd_pkg::rsp_payload_type rsp_payload
);

   logic                              seen_ff;
   logic [wmmd_pkg::PTNUM_BITS-1:0]   prev_number_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         prev_number_ff <= rsp_payload.point_number;
      end
   end

   // no point right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled point stays offered
   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before it was taken");

   // every point covers at least one frame
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.point_min <= rsp_payload.point_max))
      else $error("point min above point max");

   // points are numbered consecutively
   a_number_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && seen_ff |->
         (rsp_payload.point_number == prev_number_ff + 1'b1))
      else $error("point number skipped or repeated");

endmodule

bind waveform_minmax_decimator_core wmmd_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
